FILE: rtl/core/rmlu_pkg.sv
// Package for the record member layout unit: word types, widths and helpers.
package rmlu_pkg;

    // Default width of the running offset.
    localparam int RMLU_OFFSET_BITS = 32;

    // Fixed widths of the word fields.
    localparam int SIZE_W   = 24;
    localparam int ALIGN_W  = 17;
    localparam int BITW_W   = 7;
    localparam int OUT_OFF_W = 32;
    localparam int BOFF_W   = 6;
    localparam int UBYTES_W = 4;

    // Largest storage unit of a bit-field, in bytes.
    localparam logic [UBYTES_W-1:0] MAX_UNIT_BYTES = 4'd15;

    // One input word: a single record member.
    typedef struct packed {
        logic [SIZE_W-1:0]  member_size;
        logic [ALIGN_W-1:0] natural_align;
        logic [ALIGN_W-1:0] explicit_align;
        logic               bf_flag;
        logic [BITW_W-1:0]  bf_width;
        logic               packed_record;
        logic [ALIGN_W-1:0] record_align_req;
        logic               last_member;
    } t_member;

    // One result word.
    typedef struct packed {
        logic [OUT_OFF_W-1:0] member_offset;
        logic [BOFF_W-1:0]    member_bit_offset;
        logic                 placed;
        logic [OUT_OFF_W-1:0] record_size;
        logic [ALIGN_W-1:0]   record_alignment;
        logic                 record_done;
        logic                 overflow;
    } t_result;

    // Highest set bit of an alignment; zero reads as one.
    function automatic logic [ALIGN_W-1:0] pow2_floor(input logic [ALIGN_W-1:0] v);
        logic [ALIGN_W-1:0] s;
        s = v;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        if (v == '0) begin
            return ALIGN_W'(1);
        end
        return s ^ (s >> 1);
    endfunction

endpackage

FILE: rtl/core/rmlu_core.sv
// Layout datapath: running offset, open bit-field unit and the result register.
module rmlu_core
    import rmlu_pkg::*;
#(
    parameter int OFFSET_BITS = RMLU_OFFSET_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_member i_member,
    output t_result o_result
);

    localparam int OW = OFFSET_BITS;
    localparam int BW = (OW > SIZE_W) ? OW : SIZE_W;
    localparam int XW = (OW > OUT_OFF_W) ? OW : OUT_OFF_W;

    // Add with overflow out of the offset width; result is {overflow, sum}.
    function automatic logic [OW:0] f_add(input logic [OW-1:0] a, input logic [BW-1:0] b);
        logic [BW:0] s;
        s = (BW + 1)'(a) + (BW + 1)'(b);
        return {(|s[BW:OW]), s[OW-1:0]};
    endfunction

    // Round up to a power-of-two alignment; result is {overflow, value}.
    function automatic logic [OW:0] f_round(input logic [OW-1:0] v,
                                            input logic [ALIGN_W-1:0] al);
        logic [OW:0]         s;
        logic [ALIGN_W-1:0]  m;
        m = al - ALIGN_W'(1);
        s = f_add(v, BW'(m));
        return {s[OW], s[OW-1:0] & ~OW'(m)};
    endfunction

    // Layout state.
    logic [OW-1:0]       r_run, n_run;
    logic [ALIGN_W-1:0]  r_wide, n_wide;
    logic                r_uopen, n_uopen;
    logic [OW-1:0]       r_ustart, n_ustart;
    logic [BITW_W-1:0]   r_ubits, n_ubits;
    logic [UBYTES_W-1:0] r_ubytes, n_ubytes;
    logic                r_ovf;
    t_result             r_res, n_res;

    // Decoded member.
    logic [ALIGN_W-1:0]  na, ea, al, ra, ralign;
    logic [UBYTES_W-1:0] ub;
    logic                new_unit;
    logic [OW:0]         c_close, c_round, c_add, c_lclose, c_rround;
    logic [OW-1:0]       run_c, run_l, moff, rsize;
    logic [BITW_W-1:0]   boff;
    logic [BITW_W:0]     bits_need;
    logic                ovf_m;
    logic [XW-1:0]       moff_x, rsize_x;

    // Alignments and bit-field unit size.
    always_comb begin
        na = pow2_floor(i_member.natural_align);
        ea = (i_member.explicit_align == '0) ? '0 : pow2_floor(i_member.explicit_align);
        al = (na > ea) ? na : ea;
        ra = pow2_floor(i_member.record_align_req);
        ub = (i_member.member_size > SIZE_W'(MAX_UNIT_BYTES)) ? MAX_UNIT_BYTES
                                                            : i_member.member_size[UBYTES_W-1:0];
        bits_need = (BITW_W + 1)'(i_member.bf_width) + (BITW_W + 1)'(r_ubits);
        new_unit  = !r_uopen || (ub != r_ubytes) ||
                    (bits_need > (BITW_W + 1)'({ub, 3'b000}));
    end

    // Closing the open unit, rounding and advancing the offset.
    assign c_close = f_add(r_ustart, BW'(r_ubytes));
    assign run_c   = r_uopen ? c_close[OW-1:0] : r_run;
    assign c_round = f_round(run_c, al);
    assign c_add   = f_add(i_member.packed_record ? run_c : c_round[OW-1:0],
                           BW'(i_member.member_size));

    // Member placement and the state it leaves.
    always_comb begin
        n_run    = r_run;
        n_wide   = r_wide;
        n_uopen  = r_uopen;
        n_ustart = r_ustart;
        n_ubits  = r_ubits;
        n_ubytes = r_ubytes;
        ovf_m    = 1'b0;
        moff     = '0;
        boff     = '0;
        if (i_member.bf_flag) begin
            if (i_member.bf_width == '0) begin
                // Zero-width marker: close the unit, place nothing.
                n_run   = run_c;
                n_uopen = 1'b0;
                ovf_m   = r_uopen & c_close[OW];
            end else begin
                if (new_unit) begin
                    n_run    = c_round[OW-1:0];
                    n_ustart = c_round[OW-1:0];
                    n_ubytes = ub;
                    n_uopen  = 1'b1;
                    ovf_m    = (r_uopen & c_close[OW]) | c_round[OW];
                    moff     = c_round[OW-1:0];
                    boff     = '0;
                end else begin
                    moff = r_ustart;
                    boff = r_ubits;
                end
                n_ubits = boff + i_member.bf_width;
                if (na > r_wide) begin
                    n_wide = na;
                end
            end
        end else begin
            // Plain member: close the unit, align unless packed, then advance.
            n_uopen = 1'b0;
            n_run   = c_add[OW-1:0];
            if (i_member.packed_record) begin
                moff  = run_c;
                ovf_m = (r_uopen & c_close[OW]) | c_add[OW];
            end else begin
                moff  = c_round[OW-1:0];
                ovf_m = (r_uopen & c_close[OW]) | c_round[OW] | c_add[OW];
                if (al > r_wide) begin
                    n_wide = al;
                end
            end
        end
    end

    // Record end: close the unit and round to the record alignment.
    assign c_lclose = f_add(n_ustart, BW'(n_ubytes));
    assign run_l    = n_uopen ? c_lclose[OW-1:0] : n_run;
    assign ralign   = i_member.packed_record ? ALIGN_W'(1) : ((ra > n_wide) ? ra : n_wide);
    assign c_rround = f_round(run_l, ralign);
    assign rsize    = i_member.packed_record ? run_l : c_rround[OW-1:0];

    // Result word.
    always_comb begin
        moff_x  = XW'(moff);
        rsize_x = XW'(rsize);
        n_res.member_offset     = moff_x[OUT_OFF_W-1:0];
        n_res.member_bit_offset = boff[BOFF_W-1:0];
        n_res.placed            = !(i_member.bf_flag && (i_member.bf_width == '0));
        n_res.record_done       = i_member.last_member;
        n_res.record_size       = '0;
        n_res.record_alignment  = ALIGN_W'(1);
        n_res.overflow          = r_ovf | ovf_m;
        if (i_member.last_member) begin
            n_res.record_size      = rsize_x[OUT_OFF_W-1:0];
            n_res.record_alignment = ralign;
            n_res.overflow         = r_ovf | ovf_m | (n_uopen & c_lclose[OW]) |
                                     (!i_member.packed_record & c_rround[OW]);
        end
    end

    // State registers; the last member returns everything to reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= '0;
            r_wide   <= ALIGN_W'(1);
            r_uopen  <= 1'b0;
            r_ustart <= '0;
            r_ubits  <= '0;
            r_ubytes <= '0;
            r_ovf    <= 1'b0;
        end else if (i_en) begin
            if (i_member.last_member) begin
                r_run    <= '0;
                r_wide   <= ALIGN_W'(1);
                r_uopen  <= 1'b0;
                r_ustart <= '0;
                r_ubits  <= '0;
                r_ubytes <= '0;
                r_ovf    <= 1'b0;
            end else begin
                r_run    <= n_run;
                r_wide   <= n_wide;
                r_uopen  <= n_uopen;
                r_ustart <= n_ustart;
                r_ubits  <= n_ubits;
                r_ubytes <= n_ubytes;
                r_ovf    <= n_res.overflow;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

endmodule

FILE: rtl/core/record_member_layout_unit.sv
// Top level of the record member layout unit: handshakes, input and output registers.
//
// The block lays out the members of a record, one input word per member.
// Input channel: i_in_valid / o_in_ready with one port per member field.
// Output channel: o_out_valid / i_out_ready with one result word per member.
// Each member gets a byte offset and, for bit-fields, a bit offset; the word
// of the member flagged last also carries the record size and alignment, and
// the layout state then returns to its reset values for the next record.
// A word accepted into the input register passes the layout datapath and lands
// in the result register once the result slot is free. Throughput is one
// member per cycle while the receiver takes the results, set by the single
// pass through the offset add, align and unit-close logic.
// A synchronous active-low reset empties both registers and clears the
// running offset, the open bit-field unit and the sticky overflow flag.
// When the receiver stalls, the result word holds and the input register
// takes one more word; o_in_ready then drops until the result is taken.
module record_member_layout_unit
    import rmlu_pkg::*;
#(
    parameter int OFFSET_BITS = RMLU_OFFSET_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [SIZE_W-1:0]    i_member_size,
    input  logic [ALIGN_W-1:0]   i_natural_align,
    input  logic [ALIGN_W-1:0]   i_explicit_align,
    input  logic                 i_bf_flag,
    input  logic [BITW_W-1:0]    i_bf_width,
    input  logic                 i_packed_record,
    input  logic [ALIGN_W-1:0]   i_record_align_req,
    input  logic                 i_last_member,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [OUT_OFF_W-1:0] o_member_offset,
    output logic [BOFF_W-1:0]    o_member_bit_offset,
    output logic                 o_placed,
    output logic [OUT_OFF_W-1:0] o_record_size,
    output logic [ALIGN_W-1:0]   o_record_alignment,
    output logic                 o_record_done,
    output logic                 o_overflow
);

    t_member r_in;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    out_free;
    logic    step;
    t_result res;

    // The datapath advances when a word is held and the result slot frees up.
    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.member_size      <= i_member_size;
            r_in.natural_align    <= i_natural_align;
            r_in.explicit_align   <= i_explicit_align;
            r_in.bf_flag          <= i_bf_flag;
            r_in.bf_width         <= i_bf_width;
            r_in.packed_record    <= i_packed_record;
            r_in.record_align_req <= i_record_align_req;
            r_in.last_member      <= i_last_member;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step;
        end
    end

    rmlu_core #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (step),
        .i_member (r_in),
        .o_result (res)
    );

    assign o_out_valid         = r_out_valid;
    assign o_member_offset     = res.member_offset;
    assign o_member_bit_offset = res.member_bit_offset;
    assign o_placed            = res.placed;
    assign o_record_size       = res.record_size;
    assign o_record_alignment  = res.record_alignment;
    assign o_record_done       = res.record_done;
    assign o_overflow          = res.overflow;

endmodule

FILE: rtl/core/rmlu_checker.sv
// Port-level assertions for the record member layout unit, bound to the top level.
module rmlu_checker
    import rmlu_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [OUT_OFF_W-1:0] o_member_offset,
    input logic [BOFF_W-1:0]    o_member_bit_offset,
    input logic                 o_placed,
    input logic [OUT_OFF_W-1:0] o_record_size,
    input logic [ALIGN_W-1:0]   o_record_alignment,
    input logic                 o_record_done
);

    // The final alignment of a record is always a single power of two.
    a_align_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_record_done |-> $onehot(o_record_alignment))
        else $error("record alignment is not a power of two");

    // Words before the last one carry neutral record fields.
    a_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_record_done |->
            (o_record_size == '0) && (o_record_alignment == ALIGN_W'(1)))
        else $error("record fields set on a word that is not the last");

    // A zero-width marker gets no placement.
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_placed |->
            (o_member_offset == '0) && (o_member_bit_offset == '0))
        else $error("marker word carries an offset");

    // With the result slot empty, the block always takes input.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while no result is pending");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_member_offset) && $stable(o_record_size))
        else $error("stalled result word changed");

endmodule

bind record_member_layout_unit rmlu_checker u_rmlu_checker (.*);
